### src/pimpt_pkg.sv
// ----------------------------------------------------------------------------
// pimpt_pkg
// Shared types and constants for the point-in-mesh parity test.
// ----------------------------------------------------------------------------
package pimpt_pkg;

	// coordinate and delta widths
	localparam int CoordW = 32;
	localparam int DeltaW = CoordW + 1;
	localparam int ThrW   = 40;
	localparam int CfgIdxW = 2;

	// products, bilinear terms and the triple product
	localparam int MulAW  = DeltaW + 2;
	localparam int MulBW  = DeltaW + 1;
	localparam int ProdW  = MulAW + MulBW - 1;
	localparam int TermW  = 2 * DeltaW + 1;
	localparam int SplitW = 34;
	localparam int TnW    = 104;

	// number of multiplier issues per triangle
	localparam int NumMul = 16;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_POINT_X = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_POINT_Y = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_POINT_Z = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_DET_THR = 2'd3;

	localparam logic [ThrW-1:0] DET_THR_RESET = 40'd4295;

	// one classified triangle, as queued between front and back
	typedef struct packed {
		logic                     skip;
		logic                     last;
		logic signed [DeltaW-1:0] e1x;
		logic signed [DeltaW-1:0] e1y;
		logic signed [DeltaW-1:0] e1z;
		logic signed [DeltaW-1:0] e2x;
		logic signed [DeltaW-1:0] e2y;
		logic signed [DeltaW-1:0] e2z;
		logic signed [DeltaW-1:0] tx;
		logic signed [DeltaW-1:0] ty;
		logic signed [DeltaW-1:0] tz;
	} tri_entry_t;

	// query point and threshold as seen by front and back
	typedef struct packed {
		logic signed [CoordW-1:0] px;
		logic signed [CoordW-1:0] py;
		logic signed [CoordW-1:0] pz;
		logic        [ThrW-1:0]   thr;
	} cfg_regs_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_SIGN,
		B_DECIDE,
		B_OUT
	} back_state_t;

endpackage

### src/pimpt_fifo.sv
// ----------------------------------------------------------------------------
// pimpt_fifo
// Short register queue between the classifying front and the test back end.
// ----------------------------------------------------------------------------
module pimpt_fifo
	import pimpt_pkg::*;
#(
	parameter int Depth = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  tri_entry_t push_data,
	output logic       full,
	input  logic       pop,
	output tri_entry_t pop_data,
	output logic       empty
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	tri_entry_t            mem_q [Depth];
	logic [PtrW-1:0]       wr_ptr_q;
	logic [PtrW-1:0]       rd_ptr_q;
	logic [CntW-1:0]       count_q;

	assign full     = (count_q == CntW'(Depth));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### src/pimpt_front.sv
// ----------------------------------------------------------------------------
// pimpt_front
// Accepts triangle beats, runs the bounding rejects and forms edge deltas.
// ----------------------------------------------------------------------------
module pimpt_front
	import pimpt_pkg::*;
(
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [CoordW-1:0] a_x,
	input  logic signed [CoordW-1:0] a_y,
	input  logic signed [CoordW-1:0] a_z,
	input  logic signed [CoordW-1:0] b_x,
	input  logic signed [CoordW-1:0] b_y,
	input  logic signed [CoordW-1:0] b_z,
	input  logic signed [CoordW-1:0] c_x,
	input  logic signed [CoordW-1:0] c_y,
	input  logic signed [CoordW-1:0] c_z,
	input  logic                     last_triangle,
	input  cfg_regs_t                cfg,
	input  logic                     q_full,
	output logic                     q_push,
	output tri_entry_t               q_data
);

	logic above_z, side_x, side_y;
	logic gax, gbx, gcx, gay, gby, gcy;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// trivial rejects: all above in z, or one-sided on x or y
	always_comb begin
		above_z = (a_z > cfg.pz) && (b_z > cfg.pz) && (c_z > cfg.pz);
		gax = (a_x >= cfg.px);
		gbx = (b_x >= cfg.px);
		gcx = (c_x >= cfg.px);
		gay = (a_y >= cfg.py);
		gby = (b_y >= cfg.py);
		gcy = (c_y >= cfg.py);
		side_x = (gax && gbx && gcx) || (!gax && !gbx && !gcx);
		side_y = (gay && gby && gcy) || (!gay && !gby && !gcy);
	end

	// edge and point deltas, one bit wider than the coordinates
	always_comb begin
		q_data.skip = above_z || side_x || side_y;
		q_data.last = last_triangle;
		q_data.e1x  = DeltaW'(b_x) - DeltaW'(a_x);
		q_data.e1y  = DeltaW'(b_y) - DeltaW'(a_y);
		q_data.e1z  = DeltaW'(b_z) - DeltaW'(a_z);
		q_data.e2x  = DeltaW'(c_x) - DeltaW'(a_x);
		q_data.e2y  = DeltaW'(c_y) - DeltaW'(a_y);
		q_data.e2z  = DeltaW'(c_z) - DeltaW'(a_z);
		q_data.tx   = DeltaW'(cfg.px) - DeltaW'(a_x);
		q_data.ty   = DeltaW'(cfg.py) - DeltaW'(a_y);
		q_data.tz   = DeltaW'(cfg.pz) - DeltaW'(a_z);
	end

endmodule

### src/pimpt_back.sv
// ----------------------------------------------------------------------------
// pimpt_back
// Sequenced crossing test on one shared multiplier, parity and result beat.
// ----------------------------------------------------------------------------
module pimpt_back
	import pimpt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  tri_entry_t  q_data,
	output logic        q_pop,
	input  logic [ThrW-1:0] thr,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        inside_res
);

	back_state_t state_q, state_d;
	logic [4:0]  step_q;
	tri_entry_t  ent_q;

	logic signed [MulAW-1:0] ma;
	logic signed [MulBW-1:0] mb;
	logic signed [ProdW-1:0] mul;
	logic signed [ProdW-1:0] prod_q;

	logic signed [TermW-1:0] det_q, un_q, vn_q, qx_q, qy_q;
	logic signed [TnW-1:0]   tn_q;
	logic signed [TnW-1:0]   prod_ext, prod_hi;

	logic parity_q, out_valid_q, inside_q;
	logic out_free, load_ent, hit;
	logic signed [TermW:0]   uv_sum;

	assign out_free   = !out_valid_q || out_ready;
	assign out_valid  = out_valid_q;
	assign inside_res = inside_q;

	// next state
	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		load_ent = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					q_pop    = 1'b1;
					load_ent = 1'b1;
					if (!q_data.skip) begin
						state_d = B_MUL;
					end else if (q_data.last) begin
						state_d = B_OUT;
					end
				end
			end
			B_MUL:    if (step_q == 5'(NumMul)) state_d = B_SIGN;
			B_SIGN:   state_d = B_DECIDE;
			B_DECIDE: state_d = ent_q.last ? B_OUT : B_IDLE;
			B_OUT:    if (out_free) state_d = B_IDLE;
			default:  state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// multiplier operand schedule; wide terms split into low and high halves
	always_comb begin
		ma = '0;
		mb = '0;
		case (step_q[3:0])
			4'd0:  begin ma = MulAW'(ent_q.e1y); mb = MulBW'(ent_q.e2x); end
			4'd1:  begin ma = MulAW'(ent_q.e1x); mb = MulBW'(ent_q.e2y); end
			4'd2:  begin ma = MulAW'(ent_q.ty);  mb = MulBW'(ent_q.e2x); end
			4'd3:  begin ma = MulAW'(ent_q.tx);  mb = MulBW'(ent_q.e2y); end
			4'd4:  begin ma = MulAW'(ent_q.tx);  mb = MulBW'(ent_q.e1y); end
			4'd5:  begin ma = MulAW'(ent_q.ty);  mb = MulBW'(ent_q.e1x); end
			4'd6:  begin ma = MulAW'(ent_q.ty);  mb = MulBW'(ent_q.e1z); end
			4'd7:  begin ma = MulAW'(ent_q.tz);  mb = MulBW'(ent_q.e1y); end
			4'd8:  begin ma = MulAW'(ent_q.tz);  mb = MulBW'(ent_q.e1x); end
			4'd9:  begin ma = MulAW'(ent_q.tx);  mb = MulBW'(ent_q.e1z); end
			4'd10: begin ma = {1'b0, qx_q[SplitW-1:0]}; mb = MulBW'(ent_q.e2x); end
			4'd11: begin
				ma = MulAW'(signed'(qx_q[TermW-1:SplitW]));
				mb = MulBW'(ent_q.e2x);
			end
			4'd12: begin ma = {1'b0, qy_q[SplitW-1:0]}; mb = MulBW'(ent_q.e2y); end
			4'd13: begin
				ma = MulAW'(signed'(qy_q[TermW-1:SplitW]));
				mb = MulBW'(ent_q.e2y);
			end
			4'd14: begin ma = {1'b0, vn_q[SplitW-1:0]}; mb = MulBW'(ent_q.e2z); end
			4'd15: begin
				ma = MulAW'(signed'(vn_q[TermW-1:SplitW]));
				mb = MulBW'(ent_q.e2z);
			end
			default: begin ma = '0; mb = '0; end
		endcase
		mul = ma * mb;
	end

	assign prod_ext = TnW'(prod_q);
	assign prod_hi  = {prod_ext[TnW-SplitW-1:0], {SplitW{1'b0}}};

	// hit test on sign-corrected terms
	assign uv_sum = (TermW+1)'(un_q) + (TermW+1)'(vn_q);
	assign hit = ({(TermW-ThrW)'(0), thr} <= det_q) && !un_q[TermW-1] && !vn_q[TermW-1]
		&& (uv_sum <= (TermW+1)'(det_q)) && tn_q[TnW-1];

	// datapath
	always_ff @(posedge clk) begin
		if (load_ent) begin
			ent_q <= q_data;
		end
		if (state_q == B_MUL) begin
			prod_q <= mul;
			case (step_q)
				5'd1:  det_q <= prod_q[TermW-1:0];
				5'd2:  det_q <= det_q - prod_q[TermW-1:0];
				5'd3:  un_q  <= prod_q[TermW-1:0];
				5'd4:  un_q  <= un_q - prod_q[TermW-1:0];
				5'd5:  vn_q  <= prod_q[TermW-1:0];
				5'd6:  vn_q  <= vn_q - prod_q[TermW-1:0];
				5'd7:  qx_q  <= prod_q[TermW-1:0];
				5'd8:  qx_q  <= qx_q - prod_q[TermW-1:0];
				5'd9:  qy_q  <= prod_q[TermW-1:0];
				5'd10: qy_q  <= qy_q - prod_q[TermW-1:0];
				5'd11: tn_q  <= prod_ext;
				5'd12, 5'd14, 5'd16: tn_q <= tn_q + prod_hi;
				5'd13, 5'd15: tn_q <= tn_q + prod_ext;
				default: ;
			endcase
		end
		// fold the determinant sign into the determinant and the u, v and t terms
		if (state_q == B_SIGN && det_q[TermW-1]) begin
			det_q <= -det_q;
			un_q  <= -un_q;
			vn_q  <= -vn_q;
			tn_q  <= -tn_q;
		end
	end

	// step counter, parity and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			parity_q    <= 1'b0;
			out_valid_q <= 1'b0;
			inside_q    <= 1'b0;
		end else begin
			if (state_q == B_MUL) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
			if (state_q == B_DECIDE && hit) begin
				parity_q <= !parity_q;
			end
			if (state_q == B_OUT && out_free) begin
				out_valid_q <= 1'b1;
				inside_q    <= parity_q;
				parity_q    <= 1'b0;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### src/point_in_mesh_parity_test.sv
// ----------------------------------------------------------------------------
// point_in_mesh_parity_test
// Vertical ray parity test of a query point against a streamed triangle mesh.
//
//  channel   signals                                 beat
//  in        in_valid/in_ready, a_x..c_z, last       one triangle
//  out       out_valid/out_ready, inside_res         one result per mesh
//  cfg       cfg_valid/cfg_ready, cfg_index/cfg_data one register write
//
// A rejected triangle is only popped in the back end; a tested one is popped,
// then takes 16 issues of the single shared multiplier, a sign and a decide step.
// The last triangle of a mesh then loads the result register in an output state.
// The queue of QueueDepth beats lets the front accept while the back works.
// Reset clears the parity, the queue and the result; cfg_ready is always high.
// ----------------------------------------------------------------------------
module point_in_mesh_parity_test
	import pimpt_pkg::*;
#(
	parameter int QueueDepth = 2
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [CoordW-1:0] a_x,
	input  logic signed [CoordW-1:0] a_y,
	input  logic signed [CoordW-1:0] a_z,
	input  logic signed [CoordW-1:0] b_x,
	input  logic signed [CoordW-1:0] b_y,
	input  logic signed [CoordW-1:0] b_z,
	input  logic signed [CoordW-1:0] c_x,
	input  logic signed [CoordW-1:0] c_y,
	input  logic signed [CoordW-1:0] c_z,
	input  logic                     last_triangle,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     inside_res,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CfgIdxW-1:0]       cfg_index,
	input  logic [ThrW-1:0]          cfg_data
);

	cfg_regs_t  cfg_q;
	tri_entry_t push_data, pop_data;
	logic       push, pop, full, empty;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.px  <= '0;
			cfg_q.py  <= '0;
			cfg_q.pz  <= '0;
			cfg_q.thr <= DET_THR_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_POINT_X: cfg_q.px  <= cfg_data[CoordW-1:0];
				CFG_POINT_Y: cfg_q.py  <= cfg_data[CoordW-1:0];
				CFG_POINT_Z: cfg_q.pz  <= cfg_data[CoordW-1:0];
				CFG_DET_THR: cfg_q.thr <= cfg_data;
				default: ;
			endcase
		end
	end

	pimpt_front u_front (
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.a_x           (a_x),
		.a_y           (a_y),
		.a_z           (a_z),
		.b_x           (b_x),
		.b_y           (b_y),
		.b_z           (b_z),
		.c_x           (c_x),
		.c_y           (c_y),
		.c_z           (c_z),
		.last_triangle (last_triangle),
		.cfg           (cfg_q),
		.q_full        (full),
		.q_push        (push),
		.q_data        (push_data)
	);

	pimpt_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	pimpt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (empty),
		.q_data     (pop_data),
		.q_pop      (pop),
		.thr        (cfg_q.thr),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.inside_res (inside_res)
	);

endmodule

### src/pimpt_checker.sv
// ----------------------------------------------------------------------------
// pimpt_checker
// Port-level checks on the parity test, bound to the top level.
// ----------------------------------------------------------------------------
module pimpt_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic inside_res,
	input logic cfg_ready
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(inside_res))
		else $error("result beat changed while stalled");

	// a result beat leaves only by being taken
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result beat dropped");

	// configuration writes are never back-pressured
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("cfg_ready low");

	// handshake outputs are always known out of reset
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(in_ready) && !$isunknown(out_valid))
		else $error("unknown handshake output");

endmodule

bind point_in_mesh_parity_test pimpt_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.inside_res (inside_res),
	.cfg_ready  (cfg_ready)
);

### test/tb_point_in_mesh_parity_test.sv
// ----------------------------------------------------------------------------
// tb_point_in_mesh_parity_test
// Self-checking bench for the point-in-mesh parity test.
//
// Triangle meshes stream in through a bursty driver while the result port is
// stalled on its own pattern. Each accepted triangle goes through a local
// exact-integer ray/triangle crossing predictor. The last triangle of a mesh
// queues the expected inside flag, which the monitor checks in order. The
// query point and the threshold are rewritten between phases while the
// block is idle, the extreme settings among them.
// ----------------------------------------------------------------------------
module tb_point_in_mesh_parity_test;
	import pimpt_pkg::*;

	typedef struct packed {
		logic signed [CoordW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
		logic                     last;
	} tri_t;

	localparam int CycleLimit = 600000;
	localparam int DrainWait  = 80;
	localparam int TriSlots   = 4096;
	localparam logic signed [CoordW-1:0] ONE = 32'sh0001_0000;

	logic clk, arst_n;
	logic in_valid, in_ready;
	logic signed [CoordW-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
	logic last_triangle;
	logic out_valid, out_ready, inside_res;
	logic cfg_valid, cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [ThrW-1:0] cfg_data;

	point_in_mesh_parity_test dut (.*);

	// predictor copy of configuration and parity
	logic signed [CoordW-1:0] qp_x, qp_y, qp_z;
	logic [ThrW-1:0] qp_thr;
	bit parity_model;

	// pending triangles and expected results, each with write and read counts
	tri_t pending_tris [TriSlots];
	int   pend_wr, pend_rd;
	bit   inside_expected [TriSlots];
	int   exp_wr, exp_rd;
	tri_t cur_tri;
	int   gap_left, burst_left, stall_left, run_left;
	int   errors, cfg_beats, tri_beats, mesh_results;
	bit   hold_off;
	longint cycles;

	// clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic signed [127:0] wide_of(logic signed [CoordW-1:0] v);
		return v;
	endfunction

	function automatic bit ge_pt(logic signed [CoordW-1:0] v, logic signed [CoordW-1:0] p);
		return v >= p;
	endfunction

	// exact crossing test of a +z ray from the query point, below the point only
	function automatic bit crosses_below(tri_t t);
		logic signed [127:0] e1x, e1y, e1z, e2x, e2y, e2z, tx, ty, tz;
		logic signed [127:0] det, un, vn, qx, qy, tn, thr_w;
		bit gx0, gx1, gx2, gy0, gy1, gy2;
		if (t.az > qp_z && t.bz > qp_z && t.cz > qp_z)
			return 1'b0;
		gx0 = ge_pt(t.ax, qp_x); gx1 = ge_pt(t.bx, qp_x); gx2 = ge_pt(t.cx, qp_x);
		gy0 = ge_pt(t.ay, qp_y); gy1 = ge_pt(t.by, qp_y); gy2 = ge_pt(t.cy, qp_y);
		if ((gx0 && gx1 && gx2) || !(gx0 || gx1 || gx2))
			return 1'b0;
		if ((gy0 && gy1 && gy2) || !(gy0 || gy1 || gy2))
			return 1'b0;
		e1x = wide_of(t.bx) - wide_of(t.ax);
		e1y = wide_of(t.by) - wide_of(t.ay);
		e1z = wide_of(t.bz) - wide_of(t.az);
		e2x = wide_of(t.cx) - wide_of(t.ax);
		e2y = wide_of(t.cy) - wide_of(t.ay);
		e2z = wide_of(t.cz) - wide_of(t.az);
		tx  = wide_of(qp_x) - wide_of(t.ax);
		ty  = wide_of(qp_y) - wide_of(t.ay);
		tz  = wide_of(qp_z) - wide_of(t.az);
		det = e1y * e2x - e1x * e2y;
		un  = ty * e2x - tx * e2y;
		vn  = tx * e1y - ty * e1x;
		qx  = ty * e1z - tz * e1y;
		qy  = tz * e1x - tx * e1z;
		tn  = e2x * qx + e2y * qy + e2z * vn;
		// fold the determinant sign into the bound terms
		if (det < 0) begin
			det = -det; un = -un; vn = -vn; tn = -tn;
		end
		thr_w = {88'd0, qp_thr};
		return det >= thr_w && un >= 0 && vn >= 0 && un + vn <= det && tn < 0;
	endfunction

	function automatic tri_t make_tri(
		logic signed [CoordW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz, bit last);
		tri_t t;
		t = '{ax, ay, az, bx, by, bz, cx, cy, cz, last};
		return t;
	endfunction

	// append a triangle to the pending list
	function automatic void queue_tri(tri_t t);
		pending_tris[pend_wr] = t;
		pend_wr++;
	endfunction

	// vertex near the query point, or anywhere at all
	function automatic logic signed [CoordW-1:0] coord_near(
		logic signed [CoordW-1:0] p, int mode);
		logic signed [CoordW-1:0] r;
		r = $urandom;
		if (mode == 0)
			return r;
		return p + (r >>> $urandom_range(1, 29));
	endfunction

	function automatic tri_t rand_tri(bit last);
		int m;
		m = ($urandom_range(0, 9) < 2) ? 0 : 1;
		return make_tri(coord_near(qp_x, m), coord_near(qp_y, m), coord_near(qp_z, m),
			coord_near(qp_x, m), coord_near(qp_y, m), coord_near(qp_z, m),
			coord_near(qp_x, m), coord_near(qp_y, m), coord_near(qp_z, m), last);
	endfunction

	// register write, predictor copy follows the beat
	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [ThrW-1:0] data);
		int n;
		@(posedge clk);
		n = cfg_beats;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		wait (cfg_beats != n);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_POINT_X: qp_x = data[CoordW-1:0];
			CFG_POINT_Y: qp_y = data[CoordW-1:0];
			CFG_POINT_Z: qp_z = data[CoordW-1:0];
			CFG_DET_THR: qp_thr = data;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		wait (pend_wr == pend_rd && exp_wr == exp_rd && !in_valid);
		repeat (DrainWait) @(posedge clk);
	endtask

	task automatic set_point(logic signed [CoordW-1:0] x, y, z, logic [ThrW-1:0] thr);
		wait_idle();
		write_reg(CFG_POINT_X, {8'd0, x});
		write_reg(CFG_POINT_Y, {8'd0, y});
		write_reg(CFG_POINT_Z, {8'd0, z});
		write_reg(CFG_DET_THR, thr);
	endtask

	task automatic queue_meshes(int count);
		int n, k;
		k = 0;
		while (k < count) begin
			n = $urandom_range(1, 8);
			for (int i = 0; i < n; i++)
				queue_tri(rand_tri(i == n - 1));
			k += n;
		end
	endtask

	// cycle counter and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cfg_valid && cfg_ready)
			cfg_beats <= cfg_beats + 1;
		if (cycles > CycleLimit) begin
			$display("%0t: timeout, %0d results outstanding", $time, exp_wr - exp_rd);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// triangle driver: bursts and gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} <= '0;
			last_triangle <= 1'b0;
			gap_left <= 0;
			burst_left <= 4;
		end else begin
			if (in_valid && in_ready) begin
				tri_beats <= tri_beats + 1;
				if (crosses_below(cur_tri))
					parity_model = !parity_model;
				if (cur_tri.last) begin
					inside_expected[exp_wr] = parity_model;
					exp_wr++;
					parity_model = 1'b0;
				end
			end
			if (in_valid && !in_ready) begin
				// hold the beat
			end else if (gap_left > 0 || hold_off || pend_wr == pend_rd) begin
				in_valid <= 1'b0;
				if (gap_left > 0)
					gap_left <= gap_left - 1;
			end else begin
				cur_tri = pending_tris[pend_rd];
				pend_rd++;
				{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, last_triangle} <= cur_tri;
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// result monitor with its own stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 3;
			run_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				mesh_results <= mesh_results + 1;
				if (exp_wr == exp_rd) begin
					$display("%0t: unexpected result, expected none, actual inside_res=%0b",
						$time, inside_res);
					errors++;
				end else begin
					if (inside_res !== inside_expected[exp_rd]) begin
						$display("%0t: inside_res expected %0b actual %0b",
							$time, inside_expected[exp_rd], inside_res);
						errors++;
					end
					exp_rd++;
				end
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (run_left > 0) begin
				out_ready <= 1'b1;
				run_left <= run_left - 1;
			end else begin
				out_ready <= 1'b1;
				run_left <= $urandom_range(0, 60);
				stall_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 45);
			end
		end
	end

	// stimulus and phase control
	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_POINT_X;
		cfg_data = '0;
		hold_off = 1'b0;
		errors = 0; cfg_beats = 0; tri_beats = 0; mesh_results = 0; cycles = 0;
		pend_wr = 0; pend_rd = 0; exp_wr = 0; exp_rd = 0;
		parity_model = 1'b0;
		qp_x = '0; qp_y = '0; qp_z = '0; qp_thr = DET_THR_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset configuration: crossings, a two-crossing mesh, extremes, boundaries
		queue_tri(make_tri(-ONE, -ONE, -ONE, 2*ONE, -ONE, -ONE,
			-ONE, 2*ONE, -ONE, 1'b1));
		queue_tri(make_tri(-ONE, -ONE, -ONE, 2*ONE, -ONE, -ONE,
			-ONE, 2*ONE, -ONE, 1'b0));
		queue_tri(make_tri(-ONE, -ONE, -2*ONE, 2*ONE, -ONE, -2*ONE,
			-ONE, 2*ONE, -2*ONE, 1'b1));
		queue_tri(make_tri(-ONE, -ONE, ONE, 2*ONE, -ONE, ONE,
			-ONE, 2*ONE, ONE, 1'b1));
		queue_tri(make_tri(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
			32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0));
		queue_tri(make_tri(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
			32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
			32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 1'b1));
		// edge through the point, vertex on the point, plane through the point
		queue_tri(make_tri(-ONE, -ONE, -ONE, ONE, ONE, -ONE,
			-ONE, ONE, -ONE, 1'b1));
		queue_tri(make_tri(0, 0, -ONE, ONE, -ONE, -ONE,
			-ONE, ONE, -ONE, 1'b1));
		queue_tri(make_tri(-ONE, -ONE, 0, 2*ONE, -ONE, 0,
			-ONE, 2*ONE, 0, 1'b1));

		// zero threshold: degenerate triangles
		set_point(0, 0, 0, '0);
		queue_tri(make_tri(-ONE, -ONE, -ONE, ONE, ONE, -ONE,
			2*ONE, 2*ONE, ONE, 1'b1));
		queue_tri(make_tri(-ONE, -ONE, -ONE, -ONE, -ONE, ONE,
			ONE, ONE, -2*ONE, 1'b1));
		queue_tri(make_tri(-ONE, 0, -ONE, ONE, 0, -3*ONE,
			2*ONE, 0, ONE, 1'b1));
		queue_tri(make_tri(-ONE, -ONE, -ONE, 2*ONE, -ONE, -ONE,
			-ONE, 2*ONE, -ONE, 1'b1));

		// random phases over several settings; each waits for the block to drain
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_point($urandom, $urandom, $urandom, 40'hFF_FFFF_FFFF);
				1: set_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, '0);
				2: set_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, DET_THR_RESET);
				3: set_point($urandom >>> 8, $urandom >>> 8, $urandom >>> 8,
					{8'($urandom_range(0, 255)), $urandom});
				default: set_point($urandom, $urandom, $urandom,
					ThrW'($urandom_range(0, 70000)));
			endcase
			hold_off = 1'b1;
			queue_meshes(255);
			hold_off = 1'b0;
		end

		wait_idle();
		$display("Ran %0d triangles in %0d meshes over eight query settings,",
			tri_beats, mesh_results);
		$display("with bursty input, stalled output and %0d register writes.", cfg_beats);
		if (errors == 0 && exp_wr == exp_rd) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
